### hw/rtl/fnc_pkg.sv
// Shared constants, types and codes of the face normal and centroid block.
`timescale 1ns / 1ps
`default_nettype none
package fnc_pkg;

  localparam int MAX_SIDES   = 256;
  localparam int COORD_WIDTH = 32;

  // Coordinates are sign-extended from their low EXT_W bits.
  localparam int EXT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int EXT_SHL = 32 - EXT_W;

  localparam int CNT_W  = $clog2(MAX_SIDES + 1);
  localparam int SUM_W  = 32 + $clog2(MAX_SIDES);
  localparam int EDGE_W = 33;
  localparam int DIV_W  = 64;
  localparam int DSR_W  = 32;
  localparam int ITER_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FEW  = 2'd2,
    ST_MANY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_SHIFT,
    S_CROSS,
    S_NMAG,
    S_NORM,
    S_SQR,
    S_ROOT,
    S_DSTART,
    S_DWAIT,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

### hw/rtl/fnc_if.sv
// Valid/ready channel interfaces for vertex words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface fnc_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface fnc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] centre_z;
  logic [1:0]         status;

  modport source (output valid, normal_x, normal_y, normal_z, centre_x, centre_y, centre_z,
                  status, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, centre_x, centre_y, centre_z,
                  status, output ready);
endinterface
`default_nettype wire

### hw/rtl/fnc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fnc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [fnc_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [fnc_pkg::DSR_W-1:0] divisor_i,
  output logic      [fnc_pkg::DIV_W-1:0] quotient_o,
  output fnc_pkg::div_sts_t              sts_o
);

  logic [fnc_pkg::DSR_W:0]    rem_q, rem_sh, rem_nx;
  logic [fnc_pkg::DIV_W-1:0]  quo_q;
  logic [fnc_pkg::DSR_W-1:0]  dsr_q;
  logic [fnc_pkg::ITER_W-1:0] cnt_q;
  logic                       busy_q, done_q, ge;

  assign rem_sh = {rem_q[fnc_pkg::DSR_W-1:0], quo_q[fnc_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
        cnt_q  <= fnc_pkg::ITER_W'(fnc_pkg::DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[fnc_pkg::DIV_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == fnc_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule
`default_nettype wire

### hw/rtl/face_normal_and_centroid.sv
// Top level: unit face normal and centroid from a stream of polygon vertices.
// Throughput: vertex words are taken only while idle; input stays blocked while a face is
//   computed and while a result word waits. A face with three or more vertices runs edge,
//   shift, cross product, the one-bit-a-cycle normalize loop, the 32-step square root and
//   6 divisions on the 64-step shared divider, then registers the result word.
// Short faces skip the normal, zero-area faces skip the square root; both run 3 divisions.
// Reset (async, active low) clears the kept vertices, sums, count and all control.
`timescale 1ns / 1ps
`default_nettype none
module face_normal_and_centroid (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fnc_vertex_if.sink    vtx_i,
  fnc_result_if.source  res_o
);

  fnc_pkg::state_e state_q, state_d;

  // face accumulation
  logic signed [31:0]               vtx_q [3][3];
  logic signed [fnc_pkg::SUM_W-1:0] sum_q [3];
  logic        [fnc_pkg::CNT_W-1:0] cnt_q, cnt_nx;
  logic                             ov_q;
  logic signed [31:0]               v_in [3];
  logic                             accept;

  // normal datapath
  logic signed [fnc_pkg::EDGE_W-1:0] a_q [3];
  logic signed [fnc_pkg::EDGE_W-1:0] b_q [3];
  logic signed [63:0]                c_q [3];
  logic        [63:0]                c_mag [3];
  logic        [63:0]                orm_q;
  logic        [63:0]                sq_q, x_q, r_q, bit_q, r_plus;
  logic        [31:0]                len_q;
  logic                              zero_q;
  logic        [2:0]                 k_q, km1;
  logic        [2:0]                 d_q;

  // shared multiplier
  logic signed [fnc_pkg::EDGE_W-1:0] mul_a, mul_b;
  logic signed [2*fnc_pkg::EDGE_W-1:0] prod_full;
  logic signed [63:0]                prod_q;

  // edge shift
  logic [fnc_pkg::EDGE_W-1:0] e_or;
  logic [1:0]                 e_sh;

  // divider hookup
  logic                        div_start;
  logic [fnc_pkg::DIV_W-1:0]   div_num, div_quo;
  logic [fnc_pkg::DSR_W-1:0]   div_den;
  fnc_pkg::div_sts_t           div_sts;
  logic                        div_neg;
  logic [fnc_pkg::SUM_W-1:0]   s_mag;
  logic [31:0]                 q32, res_val;

  // results
  logic signed [31:0] nrm_q [3];
  logic signed [31:0] cen_q [3];
  logic               out_valid_q;
  fnc_pkg::status_e   status_q, status_nx;

  assign accept = vtx_i.valid && vtx_i.ready;
  assign km1    = k_q - 3'd1;

  assign v_in[0] = (vtx_i.vertex_x <<< fnc_pkg::EXT_SHL) >>> fnc_pkg::EXT_SHL;
  assign v_in[1] = (vtx_i.vertex_y <<< fnc_pkg::EXT_SHL) >>> fnc_pkg::EXT_SHL;
  assign v_in[2] = (vtx_i.vertex_z <<< fnc_pkg::EXT_SHL) >>> fnc_pkg::EXT_SHL;

  assign cnt_nx = (cnt_q < fnc_pkg::CNT_W'(fnc_pkg::MAX_SIDES)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_mag[i] = c_q[i][63] ? 64'(-c_q[i]) : 64'(c_q[i]);
    end
  end

  // edge magnitudes OR'd: a set bit at 30+s means a shift of s+1 is needed
  always_comb begin
    e_or = '0;
    for (int i = 0; i < 3; i++) begin
      e_or = e_or | (a_q[i][fnc_pkg::EDGE_W-1] ? fnc_pkg::EDGE_W'(-a_q[i]) : a_q[i])
                  | (b_q[i][fnc_pkg::EDGE_W-1] ? fnc_pkg::EDGE_W'(-b_q[i]) : b_q[i]);
    end
    if (e_or[32])      e_sh = 2'd3;
    else if (e_or[31]) e_sh = 2'd2;
    else if (e_or[30]) e_sh = 2'd1;
    else               e_sh = 2'd0;
  end

  // multiplier operands: cross terms, then squares of the normalized components
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      fnc_pkg::S_CROSS: begin
        case (k_q)
          3'd0: begin mul_a = a_q[1]; mul_b = b_q[2]; end
          3'd1: begin mul_a = a_q[2]; mul_b = b_q[1]; end
          3'd2: begin mul_a = a_q[2]; mul_b = b_q[0]; end
          3'd3: begin mul_a = a_q[0]; mul_b = b_q[2]; end
          3'd4: begin mul_a = a_q[0]; mul_b = b_q[1]; end
          3'd5: begin mul_a = a_q[1]; mul_b = b_q[0]; end
          default: ;
        endcase
      end
      fnc_pkg::S_SQR: begin
        case (k_q)
          3'd0: begin
            mul_a = $signed({1'b0, c_mag[0][31:0]});
            mul_b = mul_a;
          end
          3'd1: begin
            mul_a = $signed({1'b0, c_mag[1][31:0]});
            mul_b = mul_a;
          end
          3'd2: begin
            mul_a = $signed({1'b0, c_mag[2][31:0]});
            mul_b = mul_a;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign r_plus    = r_q + bit_q;

  // division operands: three normal components, then three centroid axes
  always_comb begin
    div_num = '0;
    div_den = '0;
    div_neg = 1'b0;
    s_mag   = '0;
    case (d_q)
      3'd0, 3'd1, 3'd2: begin
        div_num = (c_mag[d_q[1:0]] << 30) + fnc_pkg::DIV_W'(len_q >> 1);
        div_den = len_q;
        div_neg = c_q[d_q[1:0]][63];
      end
      3'd3, 3'd4, 3'd5: begin
        div_neg = sum_q[2'(d_q - 3'd3)][fnc_pkg::SUM_W-1];
        s_mag   = div_neg ? fnc_pkg::SUM_W'(-sum_q[2'(d_q - 3'd3)])
                          : fnc_pkg::SUM_W'(sum_q[2'(d_q - 3'd3)]);
        div_num = fnc_pkg::DIV_W'(s_mag) + fnc_pkg::DIV_W'(cnt_q >> 1);
        div_den = fnc_pkg::DSR_W'(cnt_q);
      end
      default: ;
    endcase
  end

  assign q32     = div_quo[31:0];
  assign res_val = div_neg ? -q32 : q32;

  always_comb begin
    if (ov_q)                          status_nx = fnc_pkg::ST_MANY;
    else if (cnt_q < fnc_pkg::CNT_W'(3)) status_nx = fnc_pkg::ST_FEW;
    else if (zero_q)                   status_nx = fnc_pkg::ST_ZERO;
    else                               status_nx = fnc_pkg::ST_OK;
  end

  fnc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

  // sequencer: next state, input ready, divider start
  always_comb begin
    state_d     = state_q;
    vtx_i.ready = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      fnc_pkg::S_IDLE: begin
        // result payload is reused by the next face, so hold input until it is taken
        vtx_i.ready = !out_valid_q;
        if (accept && vtx_i.last_vertex) begin
          state_d = (cnt_nx >= fnc_pkg::CNT_W'(3)) ? fnc_pkg::S_EDGE : fnc_pkg::S_DSTART;
        end
      end
      fnc_pkg::S_EDGE:  state_d = fnc_pkg::S_SHIFT;
      fnc_pkg::S_SHIFT: state_d = fnc_pkg::S_CROSS;
      fnc_pkg::S_CROSS: if (k_q == 3'd6) state_d = fnc_pkg::S_NMAG;
      fnc_pkg::S_NMAG:  state_d = fnc_pkg::S_NORM;
      fnc_pkg::S_NORM: begin
        if (orm_q == '0)              state_d = fnc_pkg::S_DSTART;
        else if (orm_q[63:31] == '0 && orm_q[30]) state_d = fnc_pkg::S_SQR;
      end
      fnc_pkg::S_SQR:   if (k_q == 3'd3) state_d = fnc_pkg::S_ROOT;
      fnc_pkg::S_ROOT:  if (bit_q == '0) state_d = fnc_pkg::S_DSTART;
      fnc_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_d   = fnc_pkg::S_DWAIT;
      end
      fnc_pkg::S_DWAIT: begin
        if (div_sts.done) begin
          state_d = (d_q == 3'd5) ? fnc_pkg::S_HOLD : fnc_pkg::S_DSTART;
        end
      end
      fnc_pkg::S_HOLD: begin
        if (!out_valid_q || res_o.ready) state_d = fnc_pkg::S_IDLE;
      end
      default: state_d = fnc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fnc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) vtx_q[i][j] <= '0;
        sum_q[i] <= '0;
        a_q[i]   <= '0;
        b_q[i]   <= '0;
        c_q[i]   <= '0;
        nrm_q[i] <= '0;
        cen_q[i] <= '0;
      end
      cnt_q       <= '0;
      ov_q        <= 1'b0;
      zero_q      <= 1'b0;
      k_q         <= '0;
      d_q         <= '0;
      orm_q       <= '0;
      sq_q        <= '0;
      x_q         <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      len_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= fnc_pkg::ST_OK;
    end else begin
      prod_q <= prod_full[63:0];
      if (out_valid_q && res_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        fnc_pkg::S_IDLE: begin
          if (accept) begin
            if (cnt_q < fnc_pkg::CNT_W'(fnc_pkg::MAX_SIDES)) begin
              for (int i = 0; i < 3; i++) begin
                if (cnt_q < fnc_pkg::CNT_W'(3)) vtx_q[cnt_q[1:0]][i] <= v_in[i];
                sum_q[i] <= sum_q[i] + fnc_pkg::SUM_W'(v_in[i]);
              end
              cnt_q <= cnt_nx;
            end else begin
              ov_q <= 1'b1;
            end
            zero_q <= 1'b0;
            d_q    <= 3'd3;
            for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
          end
        end
        fnc_pkg::S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            a_q[i] <= fnc_pkg::EDGE_W'(vtx_q[1][i]) - fnc_pkg::EDGE_W'(vtx_q[0][i]);
            b_q[i] <= fnc_pkg::EDGE_W'(vtx_q[2][i]) - fnc_pkg::EDGE_W'(vtx_q[0][i]);
            c_q[i] <= '0;
          end
          k_q <= '0;
        end
        fnc_pkg::S_SHIFT: begin
          for (int i = 0; i < 3; i++) begin
            a_q[i] <= a_q[i] >>> e_sh;
            b_q[i] <= b_q[i] >>> e_sh;
          end
        end
        fnc_pkg::S_CROSS: begin
          // product of step k is registered in prod_q and added in the cycle after; odd steps subtract
          if (k_q != 3'd0) begin
            if (km1[0]) c_q[km1[2:1]] <= c_q[km1[2:1]] - prod_q;
            else        c_q[km1[2:1]] <= c_q[km1[2:1]] + prod_q;
          end
          k_q <= k_q + 3'd1;
        end
        fnc_pkg::S_NMAG: begin
          orm_q <= c_mag[0] | c_mag[1] | c_mag[2];
        end
        fnc_pkg::S_NORM: begin
          // walk the largest magnitude into [2^30, 2^31), one bit a cycle
          if (orm_q == '0) begin
            zero_q <= 1'b1;
          end else if (orm_q[63:31] != '0) begin
            orm_q <= orm_q >> 1;
            for (int i = 0; i < 3; i++) c_q[i] <= c_q[i] >>> 1;
          end else if (!orm_q[30]) begin
            orm_q <= orm_q << 1;
            for (int i = 0; i < 3; i++) c_q[i] <= c_q[i] <<< 1;
          end else begin
            k_q  <= '0;
            sq_q <= '0;
          end
        end
        fnc_pkg::S_SQR: begin
          if (k_q == 3'd3) begin
            x_q   <= sq_q + 64'(prod_q);
            r_q   <= '0;
            bit_q <= 64'd1 << 62;
          end else if (k_q != 3'd0) begin
            sq_q <= sq_q + 64'(prod_q);
          end
          k_q <= k_q + 3'd1;
        end
        fnc_pkg::S_ROOT: begin
          if (bit_q == '0) begin
            len_q <= r_q[31:0];
            d_q   <= 3'd0;
          end else begin
            if (x_q >= r_plus) begin
              x_q <= x_q - r_plus;
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        fnc_pkg::S_DWAIT: begin
          if (div_sts.done) begin
            if (d_q < 3'd3) nrm_q[d_q[1:0]] <= res_val;
            else            cen_q[2'(d_q - 3'd3)] <= res_val;
            d_q <= d_q + 3'd1;
          end
        end
        fnc_pkg::S_HOLD: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            status_q    <= status_nx;
            for (int i = 0; i < 3; i++) sum_q[i] <= '0;
            cnt_q <= '0;
            ov_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.normal_x = nrm_q[0];
  assign res_o.normal_y = nrm_q[1];
  assign res_o.normal_z = nrm_q[2];
  assign res_o.centre_x = cen_q[0];
  assign res_o.centre_y = cen_q[1];
  assign res_o.centre_z = cen_q[2];
  assign res_o.status   = status_q;

  // vertex count saturates at the side limit
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fnc_pkg::CNT_W'(fnc_pkg::MAX_SIDES))
    else $error("vertex count beyond side limit");

  // divider is never restarted while iterating
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // an ok face has a nonzero normal whose x component is within unit length
  a_ok_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == fnc_pkg::ST_OK) |->
      ((res_o.normal_x != 0 || res_o.normal_y != 0 || res_o.normal_z != 0) &&
       res_o.normal_x <= 32'sd1073741824 && res_o.normal_x >= -32'sd1073741824))
    else $error("bad normal on ok face");

  // short and zero-area faces report a zero normal
  a_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == fnc_pkg::ST_FEW || res_o.status == fnc_pkg::ST_ZERO))
      |-> (res_o.normal_x == 0 && res_o.normal_y == 0 && res_o.normal_z == 0))
    else $error("nonzero normal on degenerate face");

endmodule
`default_nettype wire

### dv/fnc_checker.sv
// Checker: predicts face normal and centroid words and compares them with the block.
`timescale 1ns / 1ps
module fnc_checker
  import fnc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  fnc_vertex_if        vtx_i,
  fnc_result_if        res_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct {
    logic signed [31:0] nrm[3];
    logic signed [31:0] cen[3];
    status_e            st;
  } face_word_t;

  face_word_t         face_q[$];
  logic signed [31:0] corner[3][3];  // first three vertices of the face
  longint             coord_acc[3];
  int                 vtx_cnt;
  bit                 dropped;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // round to nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned q;
    q = (mag(num) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void unit_normal(output longint n[3], output bit flat);
    longint          a[3], b[3], c[3];
    longint unsigned m, sq, len;
    int              s;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(corner[1][i]) - longint'(corner[0][i]);
      b[i] = longint'(corner[2][i]) - longint'(corner[0][i]);
      if (mag(a[i]) > m) m = mag(a[i]);
      if (mag(b[i]) > m) m = mag(b[i]);
    end
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      a[i] = a[i] >>> s;
      b[i] = b[i] >>> s;
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    m = 0;
    for (int i = 0; i < 3; i++) if (mag(c[i]) > m) m = mag(c[i]);
    for (int i = 0; i < 3; i++) n[i] = 0;
    flat = (m == 0);
    if (flat) return;
    // bring the largest component into [2^30, 2^31)
    s = 0;
    while ((m >> s) >= (64'd1 << 31)) s++;
    if (s > 0) begin
      for (int i = 0; i < 3; i++) c[i] = c[i] >>> s;
    end else begin
      while ((m << s) < (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) c[i] = c[i] <<< s;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + mag(c[i]) * mag(c[i]);
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) n[i] = round_div(c[i] <<< 30, len);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] v[3];
    longint             n[3];
    bit                 flat;
    face_word_t         w, exp_w;
    if (!rst_ni) begin
      face_q.delete();
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) corner[i][j] = '0;
        coord_acc[i] = 0;
      end
      vtx_cnt      = 0;
      dropped      = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (vtx_i.valid && vtx_i.ready) begin
        v[0] = $signed(vtx_i.vertex_x << EXT_SHL) >>> EXT_SHL;
        v[1] = $signed(vtx_i.vertex_y << EXT_SHL) >>> EXT_SHL;
        v[2] = $signed(vtx_i.vertex_z << EXT_SHL) >>> EXT_SHL;
        if (vtx_cnt < MAX_SIDES) begin
          for (int i = 0; i < 3; i++) begin
            if (vtx_cnt < 3) corner[vtx_cnt][i] = v[i];
            coord_acc[i] += v[i];
          end
          vtx_cnt++;
        end else begin
          dropped = 1;
        end
        if (vtx_i.last_vertex) begin
          flat = 0;
          for (int i = 0; i < 3; i++) n[i] = 0;
          if (vtx_cnt >= 3) begin
            unit_normal(n, flat);
            w.st = flat ? ST_ZERO : ST_OK;
          end else begin
            w.st = ST_FEW;
          end
          if (dropped) w.st = ST_MANY;
          for (int i = 0; i < 3; i++) begin
            w.nrm[i] = n[i][31:0];
            w.cen[i] = vtx_cnt ? 32'(round_div(coord_acc[i], vtx_cnt)) : '0;
            coord_acc[i] = 0;
          end
          vtx_cnt = 0;
          dropped = 0;
          face_q.push_back(w);
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (face_q.size() == 0) begin
          $display("%0t: result word with no face pending", $time);
          fail_count_o++;
        end else begin
          exp_w = face_q.pop_front();
          if (res_i.normal_x !== exp_w.nrm[0]) report("normal_x", res_i.normal_x, exp_w.nrm[0]);
          if (res_i.normal_y !== exp_w.nrm[1]) report("normal_y", res_i.normal_y, exp_w.nrm[1]);
          if (res_i.normal_z !== exp_w.nrm[2]) report("normal_z", res_i.normal_z, exp_w.nrm[2]);
          if (res_i.centre_x !== exp_w.cen[0]) report("centre_x", res_i.centre_x, exp_w.cen[0]);
          if (res_i.centre_y !== exp_w.cen[1]) report("centre_y", res_i.centre_y, exp_w.cen[1]);
          if (res_i.centre_z !== exp_w.cen[2]) report("centre_z", res_i.centre_z, exp_w.cen[2]);
          if (res_i.status !== exp_w.st) report("status", res_i.status, exp_w.st);
        end
      end
      pending_o = face_q.size();
    end
  end

endmodule

### dv/tb_top.sv
// Testbench top: vertex stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps
module tb_top;
  import fnc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 800;   // beyond the worst face latency
  localparam int ITEM_GOAL   = 1450;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct;  // chance per word that the sender idles first
  int   recv_stall_pct; // chance per cycle that the receiver stalls
  int   words_sent;
  int   faces_sent;
  int   cycles;

  fnc_vertex_if vtx_if ();
  fnc_result_if res_if ();

  face_normal_and_centroid i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_if),
    .res_o  (res_if)
  );

  fnc_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d faces still pending", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result back-pressure, re-rolled on every falling edge.
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one vertex word; the sender may idle first. valid stays up between
  // back-to-back words, so it is never lowered and raised in one step.
  task automatic send_word(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx_if.valid       <= 1'b1;
    vtx_if.vertex_x    <= x;
    vtx_if.vertex_y    <= y;
    vtx_if.vertex_z    <= z;
    vtx_if.last_vertex <= last;
    do @(posedge clk_i); while (!vtx_if.ready);
    @(negedge clk_i);
    words_sent++;
    if (last) faces_sent++;
  endtask

  // Sender goes quiet until every face result has come back, then lets
  // the block settle.
  task automatic drain();
    vtx_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Coordinate styles: full range, a small box, or the range extremes.
  function automatic logic signed [31:0] pick_coord(int style);
    case (style)
      0:       return $urandom;
      1:       return $signed($urandom_range(2000000)) - 1000000;
      default: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // A face of n vertices. Flat faces put the first three vertices on a line,
  // which also covers repeated points when the step is zero.
  task automatic send_face(int n, int style, bit flat);
    logic signed [31:0] p[3], d[3];
    for (int k = 0; k < 3; k++) begin
      p[k] = $signed($urandom_range(2000000)) - 1000000;
      d[k] = $signed($urandom_range(20000)) - 10000;
      if ($urandom_range(3) == 0) d[k] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (flat && i < 3)
        send_word(p[0] + i * d[0], p[1] + i * d[1], p[2] + i * d[2], i == n - 1);
      else
        send_word(pick_coord(style), pick_coord(style), pick_coord(style), i == n - 1);
    end
  endtask

  function automatic int face_size();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 3;
    if (r < 65) return $urandom_range(1, 2);
    return $urandom_range(4, 8);
  endfunction

  initial begin
    int style;
    rst_ni             = 1'b0;
    vtx_if.valid       = 1'b0;
    vtx_if.vertex_x    = '0;
    vtx_if.vertex_y    = '0;
    vtx_if.vertex_z    = '0;
    vtx_if.last_vertex = 1'b0;
    res_if.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    words_sent         = 0;
    faces_sent         = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed faces
    // single vertex and two vertex faces: too few for a normal
    send_word(32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1);
    send_word(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b1);
    // unit right triangle in the xy plane: normal +z
    send_word(0, 0, 0, 1'b0);
    send_word(32'sh00010000, 0, 0, 1'b0);
    send_word(0, 32'sh00010000, 0, 1'b1);
    // triangle spanning the whole range, forces the edge prescale
    send_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_word(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_word(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    // all corners equal: zero area
    send_word(-5, 7, 32'sh7fffffff, 1'b0);
    send_word(-5, 7, 32'sh7fffffff, 1'b0);
    send_word(-5, 7, 32'sh7fffffff, 1'b1);
    // tiny triangle, one LSB edges: cross product scaled up
    send_word(-1, -1, -1, 1'b0);
    send_word(0, -1, -1, 1'b0);
    send_word(-1, -1, 0, 1'b1);
    // quad with the fourth vertex only in the centroid, rounding to -0.5
    send_word(0, 0, 0, 1'b0);
    send_word(0, 0, 1, 1'b0);
    send_word(0, 1, 0, 1'b0);
    send_word(-3, -3, -3, 1'b1);
    drain();

    // Random faces, four idling phases. A long face past the side limit
    // opens the last two phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase >= 2) send_face(MAX_SIDES + 1 + $urandom_range(4), $urandom_range(2), 0);
      while (words_sent < 20 + (phase + 1) * (ITEM_GOAL - 20) / 4) begin
        style = $urandom_range(2);
        send_face(face_size(), style, $urandom_range(9) < 2);
      end
      drain();
    end

    $display("Covered %0d vertex words in %0d faces: short, flat, oversized and full-range",
             words_sent, faces_sent);
    $display("faces, under four sender/receiver idling mixes, %0d cycles", cycles);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### face_normal_and_centroid.f
hw/rtl/fnc_pkg.sv
hw/rtl/fnc_if.sv
hw/rtl/fnc_div.sv
hw/rtl/face_normal_and_centroid.sv
dv/fnc_checker.sv
dv/tb_top.sv
